>>> rtl/lev_pkg.sv
// shared types and constants for the lattice epidemic vaccination block
// no dependencies
package lev_pkg;

   localparam int COUNT_W = 17;
   localparam int THR_W   = 32;

   typedef logic [1:0] cell_type;
   localparam cell_type CELL_SUS = 2'd0;
   localparam cell_type CELL_INF = 2'd1;
   localparam cell_type CELL_VAX = 2'd2;

   typedef logic [1:0] event_type;
   localparam event_type EV_NONE   = 2'd0;
   localparam event_type EV_INFECT = 2'd1;
   localparam event_type EV_VAX    = 2'd2;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef logic [1:0] dir_type;
   localparam dir_type DIR_ROW_INC = 2'd0;
   localparam dir_type DIR_ROW_DEC = 2'd1;
   localparam dir_type DIR_COL_INC = 2'd2;
   localparam dir_type DIR_COL_DEC = 2'd3;

   localparam logic REG_INFECT_THR = 1'b0;
   localparam logic REG_VAX_THR    = 1'b1;

   localparam logic [THR_W-1:0] INFECT_THR_RESET = 32'd3650722202;
   localparam logic [THR_W-1:0] VAX_THR_RESET    = 32'd10737418;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

endpackage

>>> rtl/lattice_epidemic_vaccination_step.sv
// an accepted request passes the read state (registered lattice read) and evaluate,
//   which loads the response register once free; that register decouples the next
//   request; a new request is taken only in idle, after the read-then-evaluate turn
//   through the single lattice memory (address, registered read, write back)
// reset: synchronous; after reset a clearing pass writes every cell, SIDE*SIDE
//   cells (65536 at default), with req_stall high; csr writes are taken throughout
module lattice_epidemic_vaccination_step #(
   parameter int SIDE = 256
) (
   input  logic         clock,
   input  logic         reset,

   // configuration writes
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata,

   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_type,
   input  logic [7:0]   req_row,
   input  logic [7:0]   req_col,
   input  logic [1:0]   req_direction,
   input  logic [31:0]  req_rand_act,
   input  logic [31:0]  req_rand_vax,

   // response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_cell_state,
   output logic [1:0]   rsp_event_kind,
   output logic [16:0]  rsp_susceptible_count,
   output logic [16:0]  rsp_infected_count,
   output logic [16:0]  rsp_vaccinated_count
);

   localparam int CW     = $clog2(SIDE);
   localparam int CELLS  = SIDE * SIDE;
   localparam int AW     = $clog2(CELLS);
   localparam int CNT_W  = lev_pkg::COUNT_W;
   localparam logic [AW-1:0] CENTER   = AW'((SIDE / 2) * SIDE + SIDE / 2);
   localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
   localparam logic [CNT_W-1:0] SUS_RESET = CNT_W'(CELLS - 1);

   // reduce an 8-bit coordinate modulo SIDE by restoring subtraction
   function automatic logic [CW-1:0] wrap_coord(input logic [7:0] v);
      logic [8:0] rem;
      rem = {1'b0, v};
      for (int k = 7; k >= 0; k--) begin
         if (19'(rem) >= (19'(SIDE) << k)) begin
            rem = 9'(19'(rem) - (19'(SIDE) << k));
         end
      end
      return CW'(rem);
   endfunction

   // control state
   lev_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;

   // configuration
   logic [31:0] infect_thr_ff, infect_thr_in;
   logic [31:0] vax_thr_ff, vax_thr_in;

   // population counts
   logic [CNT_W-1:0] sus_ff, sus_in;
   logic [CNT_W-1:0] inf_ff, inf_in;
   logic [CNT_W-1:0] vax_ff, vax_in;

   // request held while in flight
   logic              typ_ff, typ_in;
   logic [CW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   lev_pkg::dir_type  dir_ff, dir_in;
   logic              fire_inf_ff, fire_inf_in;
   logic              fire_vax_ff, fire_vax_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   lev_pkg::cell_type    rsp_cell_ff, rsp_cell_in;
   lev_pkg::event_type   rsp_kind_ff, rsp_kind_in;
   logic [CNT_W-1:0]     rsp_sus_ff, rsp_sus_in;
   logic [CNT_W-1:0]     rsp_inf_ff, rsp_inf_in;
   logic [CNT_W-1:0]     rsp_vax_ff, rsp_vax_in;

   // datapath wires
   logic              req_accept;
   logic              out_free;
   logic              eval_done;
   logic              do_infect;
   logic              do_vax;
   logic [AW-1:0]     act_addr;
   logic [AW-1:0]     nb_addr;
   lev_pkg::cell_type act_q;
   lev_pkg::cell_type nb_q;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   lev_pkg::cell_type wr_data;

   // addresses follow the held request, so the read repeats while the response waits
   lev_addr #(
      .SIDE (SIDE)
   ) u_addr (
      .row       (row_ff),
      .col       (col_ff),
      .direction (dir_ff),
      .act_addr  (act_addr),
      .nb_addr   (nb_addr)
   );

   lev_ram #(
      .WIDTH (2),
      .DEPTH (CELLS)
   ) u_lattice (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (act_addr),
      .rd_data_a (act_q),
      .rd_addr_b (nb_addr),
      .rd_data_b (nb_q)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eval_done = (state_ff == lev_pkg::ST_EVAL) && out_free;

   // active and neighbor are never the same cell, so at most one write per update
   assign do_infect = (typ_ff == lev_pkg::REQ_UPDATE) && fire_inf_ff
                      && (act_q == lev_pkg::CELL_INF) && (nb_q == lev_pkg::CELL_SUS);
   assign do_vax    = (typ_ff == lev_pkg::REQ_UPDATE) && fire_vax_ff
                      && (act_q == lev_pkg::CELL_SUS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lev_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = lev_pkg::ST_IDLE;
            end
         end
         lev_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lev_pkg::ST_READ;
            end
         end
         lev_pkg::ST_READ: begin
            state_in = lev_pkg::ST_EVAL;
         end
         lev_pkg::ST_EVAL: begin
            if (out_free) begin
               state_in = lev_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lev_pkg::ST_CLEAR;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      wr_en     = 1'b0;
      wr_addr   = act_addr;
      wr_data   = lev_pkg::CELL_SUS;
      case (state_ff)
         lev_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == CENTER) ? lev_pkg::CELL_INF : lev_pkg::CELL_SUS;
         end
         lev_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         lev_pkg::ST_READ: begin
            req_stall = 1'b1;
         end
         lev_pkg::ST_EVAL: begin
            if (out_free && do_infect) begin
               wr_en   = 1'b1;
               wr_addr = nb_addr;
               wr_data = lev_pkg::CELL_INF;
            end else if (out_free && do_vax) begin
               wr_en   = 1'b1;
               wr_addr = act_addr;
               wr_data = lev_pkg::CELL_VAX;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign req_accept = req_valid && !req_stall;
   assign clr_in     = (state_ff == lev_pkg::ST_CLEAR) ? AW'(clr_ff + 1'b1) : clr_ff;

   // configuration writes
   always_comb begin
      infect_thr_in = infect_thr_ff;
      vax_thr_in    = vax_thr_ff;
      if (csr_write) begin
         case (csr_index)
            lev_pkg::REG_INFECT_THR: infect_thr_in = csr_wdata;
            lev_pkg::REG_VAX_THR:    vax_thr_in    = csr_wdata;
            default:                 infect_thr_in = infect_thr_ff;
         endcase
      end
   end

   // capture request; thresholds are compared on acceptance, not while in flight
   always_comb begin
      typ_in      = typ_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      dir_in      = dir_ff;
      fire_inf_in = fire_inf_ff;
      fire_vax_in = fire_vax_ff;
      if (req_accept) begin
         typ_in      = req_type;
         row_in      = wrap_coord(req_row);
         col_in      = wrap_coord(req_col);
         dir_in      = req_direction;
         fire_inf_in = req_rand_act < infect_thr_ff;
         fire_vax_in = req_rand_vax < vax_thr_ff;
      end
   end

   // counts and response
   always_comb begin
      sus_in       = sus_ff;
      inf_in       = inf_ff;
      vax_in       = vax_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sus_in   = rsp_sus_ff;
      rsp_inf_in   = rsp_inf_ff;
      rsp_vax_in   = rsp_vax_ff;
      if (eval_done) begin
         rsp_valid_in = 1'b1;
         rsp_cell_in  = act_q;
         rsp_kind_in  = lev_pkg::EV_NONE;
         if (do_infect) begin
            sus_in      = CNT_W'(sus_ff - 1'b1);
            inf_in      = CNT_W'(inf_ff + 1'b1);
            rsp_kind_in = lev_pkg::EV_INFECT;
         end else if (do_vax) begin
            sus_in      = CNT_W'(sus_ff - 1'b1);
            vax_in      = CNT_W'(vax_ff + 1'b1);
            rsp_kind_in = lev_pkg::EV_VAX;
            rsp_cell_in = lev_pkg::CELL_VAX;
         end
         rsp_sus_in = sus_in;
         rsp_inf_in = inf_in;
         rsp_vax_in = vax_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lev_pkg::ST_CLEAR;
         clr_ff        <= '0;
         infect_thr_ff <= lev_pkg::INFECT_THR_RESET;
         vax_thr_ff    <= lev_pkg::VAX_THR_RESET;
         sus_ff        <= SUS_RESET;
         inf_ff        <= CNT_W'(1);
         vax_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         infect_thr_ff <= infect_thr_in;
         vax_thr_ff    <= vax_thr_in;
         sus_ff        <= sus_in;
         inf_ff        <= inf_in;
         vax_ff        <= vax_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      typ_ff      <= typ_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      dir_ff      <= dir_in;
      fire_inf_ff <= fire_inf_in;
      fire_vax_ff <= fire_vax_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_sus_ff  <= rsp_sus_in;
      rsp_inf_ff  <= rsp_inf_in;
      rsp_vax_ff  <= rsp_vax_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cell_state        = rsp_cell_ff;
   assign rsp_event_kind        = rsp_kind_ff;
   assign rsp_susceptible_count = rsp_sus_ff;
   assign rsp_infected_count    = rsp_inf_ff;
   assign rsp_vaccinated_count  = rsp_vax_ff;

endmodule

>>> rtl/lev_ram.sv
// generic simple ram: one write port, two registered read ports
// no dependencies
module lev_ram #(
   parameter int WIDTH  = 2,
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> rtl/lev_addr.sv
// lattice address generation: active cell and wrapped neighbor
// depends on lev_pkg
module lev_addr #(
   parameter int SIDE = 256,
   parameter int CW   = $clog2(SIDE),
   parameter int AW   = $clog2(SIDE * SIDE)
) (
   input  logic [CW-1:0]          row,
   input  logic [CW-1:0]          col,
   input  lev_pkg::dir_type       direction,
   output logic [AW-1:0]          act_addr,
   output logic [AW-1:0]          nb_addr
);

   localparam logic [CW-1:0] LAST = CW'(SIDE - 1);

   logic [CW-1:0] nb_row;
   logic [CW-1:0] nb_col;

   always_comb begin
      nb_row = row;
      nb_col = col;
      case (direction)
         lev_pkg::DIR_ROW_INC: begin
            nb_row = (row == LAST) ? '0 : CW'(row + 1'b1);
         end
         lev_pkg::DIR_ROW_DEC: begin
            nb_row = (row == '0) ? LAST : CW'(row - 1'b1);
         end
         lev_pkg::DIR_COL_INC: begin
            nb_col = (col == LAST) ? '0 : CW'(col + 1'b1);
         end
         lev_pkg::DIR_COL_DEC: begin
            nb_col = (col == '0) ? LAST : CW'(col - 1'b1);
         end
         default: begin
            nb_col = col;
         end
      endcase
   end

   // row-major linear index, constant multiplier
   assign act_addr = AW'(AW'(row) * AW'(SIDE) + AW'(col));
   assign nb_addr  = AW'(AW'(nb_row) * AW'(SIDE) + AW'(nb_col));

endmodule

>>> tb/lattice_epidemic_vaccination_step_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the lattice epidemic vaccination block: a table of directed
// requests, then seeded random phases over several threshold settings, checked in order
// depends on lev_pkg and lattice_epidemic_vaccination_step
module lattice_epidemic_vaccination_step_tb;

   localparam int SIDE           = 256;
   localparam int CENTER         = (SIDE / 2) * SIDE + SIDE / 2;
   localparam int SETTLE_CYCLES  = 6;
   localparam int LONG_HOLD      = 300;
   // the clearing pass after reset writes all SIDE*SIDE cells with no handshake
   localparam int WATCHDOG_LIMIT = 4 * SIDE * SIDE;

   typedef struct packed {
      logic             kind;
      logic [7:0]       row;
      logic [7:0]       col;
      lev_pkg::dir_type dir;
      logic [31:0]      ract;
      logic [31:0]      rvax;
   } request_type;

   typedef struct packed {
      lev_pkg::cell_type  cell_st;
      lev_pkg::event_type kind;
      logic [16:0]        sus;
      logic [16:0]        inf;
      logic [16:0]        vax;
   } outcome_type;

   typedef struct packed {
      request_type rq;
      logic        is_fixed;
      outcome_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic        csr_index = lev_pkg::REG_INFECT_THR;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = lev_pkg::REQ_READ;
   logic [7:0]  req_row = '0;
   logic [7:0]  req_col = '0;
   logic [1:0]  req_direction = lev_pkg::DIR_ROW_INC;
   logic [31:0] req_rand_act = '0;
   logic [31:0] req_rand_vax = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_cell_state;
   logic [1:0]  rsp_event_kind;
   logic [16:0] rsp_susceptible_count;
   logic [16:0] rsp_infected_count;
   logic [16:0] rsp_vaccinated_count;

   // bench copy of the lattice, the population totals and both thresholds
   lev_pkg::cell_type grid [SIDE * SIDE];
   int unsigned sus_total;
   int unsigned inf_total;
   int unsigned vax_total;
   logic [31:0] infect_thr = lev_pkg::INFECT_THR_RESET;
   logic [31:0] vax_thr    = lev_pkg::VAX_THR_RESET;

   int          infected_sites [$];   // cells known infected, used to aim updates
   outcome_type pending_outcomes [$]; // responses still owed by the block, oldest first
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   logic        sender_quiet = 1'b0;
   logic        receiver_quiet = 1'b0;
   logic        hold_off_req = 1'b0;

   localparam logic [31:0] T_INF = lev_pkg::INFECT_THR_RESET;
   localparam logic [31:0] T_VAX = lev_pkg::VAX_THR_RESET;

   // directed requests, all under the reset thresholds; typed expectations only where obvious
   directed_row_type directed_rows [20] = '{
      // fresh lattice: only the center is infected
      '{'{lev_pkg::REQ_READ, 8'd128, 8'd128, lev_pkg::DIR_ROW_INC, 32'd0, 32'd0}, 1'b1,
        '{lev_pkg::CELL_INF, lev_pkg::EV_NONE, 17'd65535, 17'd1, 17'd0}},
      '{'{lev_pkg::REQ_READ, 8'd0, 8'd0, lev_pkg::DIR_ROW_INC, 32'd0, 32'd0}, 1'b1,
        '{lev_pkg::CELL_SUS, lev_pkg::EV_NONE, 17'd65535, 17'd1, 17'd0}},
      // read ignores direction and both draws, even a draw that would vaccinate
      '{'{lev_pkg::REQ_READ, 8'd255, 8'd255, lev_pkg::DIR_COL_DEC,
          32'hFFFF_FFFF, 32'd0}, 1'b1,
        '{lev_pkg::CELL_SUS, lev_pkg::EV_NONE, 17'd65535, 17'd1, 17'd0}},
      // center infects all four neighbors, one of them right below the threshold
      '{'{lev_pkg::REQ_UPDATE, 8'd128, 8'd128, lev_pkg::DIR_ROW_INC,
          32'd0, 32'hFFFF_FFFF}, 1'b1,
        '{lev_pkg::CELL_INF, lev_pkg::EV_INFECT, 17'd65534, 17'd2, 17'd0}},
      '{'{lev_pkg::REQ_UPDATE, 8'd128, 8'd128, lev_pkg::DIR_ROW_DEC,
          T_INF - 32'd1, 32'hFFFF_FFFF}, 1'b1,
        '{lev_pkg::CELL_INF, lev_pkg::EV_INFECT, 17'd65533, 17'd3, 17'd0}},
      '{'{lev_pkg::REQ_UPDATE, 8'd128, 8'd128, lev_pkg::DIR_COL_INC, 32'd0, 32'd0}, 1'b1,
        '{lev_pkg::CELL_INF, lev_pkg::EV_INFECT, 17'd65532, 17'd4, 17'd0}},
      '{'{lev_pkg::REQ_UPDATE, 8'd128, 8'd128, lev_pkg::DIR_COL_DEC, 32'd0, 32'd0}, 1'b1,
        '{lev_pkg::CELL_INF, lev_pkg::EV_INFECT, 17'd65531, 17'd5, 17'd0}},
      // draw equal to the threshold and the all-ones draw do not fire
      '{'{lev_pkg::REQ_UPDATE, 8'd129, 8'd128, lev_pkg::DIR_ROW_INC, T_INF, 32'd0}, 1'b1,
        '{lev_pkg::CELL_INF, lev_pkg::EV_NONE, 17'd65531, 17'd5, 17'd0}},
      '{'{lev_pkg::REQ_UPDATE, 8'd129, 8'd128, lev_pkg::DIR_ROW_INC,
          32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
      // susceptible corner gets vaccinated, then stays put
      '{'{lev_pkg::REQ_UPDATE, 8'd0, 8'd0, lev_pkg::DIR_ROW_DEC, 32'd0, 32'd0}, 1'b1,
        '{lev_pkg::CELL_VAX, lev_pkg::EV_VAX, 17'd65530, 17'd5, 17'd1}},
      '{'{lev_pkg::REQ_UPDATE, 8'd0, 8'd0, lev_pkg::DIR_ROW_DEC, 32'd0, 32'd0}, 1'b1,
        '{lev_pkg::CELL_VAX, lev_pkg::EV_NONE, 17'd65530, 17'd5, 17'd1}},
      '{'{lev_pkg::REQ_UPDATE, 8'd255, 8'd255, lev_pkg::DIR_COL_INC,
          32'd0, T_VAX}, 1'b0, '0},
      '{'{lev_pkg::REQ_UPDATE, 8'd255, 8'd255, lev_pkg::DIR_COL_INC,
          32'd0, T_VAX - 32'd1}, 1'b0, '0},
      // vaccinated cell blocks the spread
      '{'{lev_pkg::REQ_UPDATE, 8'd130, 8'd128, lev_pkg::DIR_ROW_INC, 32'd0, 32'd0},
        1'b0, '0},
      '{'{lev_pkg::REQ_UPDATE, 8'd129, 8'd128, lev_pkg::DIR_ROW_INC, 32'd0, 32'd0},
        1'b0, '0},
      '{'{lev_pkg::REQ_UPDATE, 8'd128, 8'd129, lev_pkg::DIR_ROW_DEC,
          32'd0, 32'h8000_0000}, 1'b0, '0},
      '{'{lev_pkg::REQ_READ, 8'd129, 8'd128, lev_pkg::DIR_ROW_DEC,
          32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
      '{'{lev_pkg::REQ_READ, 8'd130, 8'd128, lev_pkg::DIR_COL_INC, 32'd0, 32'd0},
        1'b0, '0},
      '{'{lev_pkg::REQ_UPDATE, 8'd127, 8'd128, lev_pkg::DIR_COL_DEC, 32'd0, 32'd0},
        1'b0, '0},
      '{'{lev_pkg::REQ_READ, 8'd255, 8'd0, lev_pkg::DIR_ROW_INC, 32'd0, 32'd0},
        1'b0, '0}
   };

   lattice_epidemic_vaccination_step dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_row              (req_row),
      .req_col              (req_col),
      .req_direction        (req_direction),
      .req_rand_act         (req_rand_act),
      .req_rand_vax         (req_rand_vax),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cell_state       (rsp_cell_state),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_susceptible_count(rsp_susceptible_count),
      .rsp_infected_count   (rsp_infected_count),
      .rsp_vaccinated_count (rsp_vaccinated_count)
   );

   always #10 clock = ~clock;

   // torus neighbor of a cell index
   function automatic int neighbor_of(int site, lev_pkg::dir_type d);
      int r;
      int c;
      r = site / SIDE;
      c = site % SIDE;
      case (d)
         lev_pkg::DIR_ROW_INC: r = (r + 1) % SIDE;
         lev_pkg::DIR_ROW_DEC: r = (r + SIDE - 1) % SIDE;
         lev_pkg::DIR_COL_INC: c = (c + 1) % SIDE;
         default:              c = (c + SIDE - 1) % SIDE;
      endcase
      return r * SIDE + c;
   endfunction

   // apply one request to the bench lattice and return the response it should produce
   function automatic outcome_type advance_lattice(request_type rq);
      int          act;
      int          nb;
      outcome_type res;
      act = (int'(rq.row) % SIDE) * SIDE + int'(rq.col) % SIDE;
      res.kind = lev_pkg::EV_NONE;
      if (rq.kind == lev_pkg::REQ_UPDATE) begin
         nb = neighbor_of(act, rq.dir);
         // infection needs an infected source and a susceptible target
         if (rq.ract < infect_thr && grid[act] == lev_pkg::CELL_INF
             && grid[nb] == lev_pkg::CELL_SUS) begin
            grid[nb] = lev_pkg::CELL_INF;
            sus_total--;
            inf_total++;
            res.kind = lev_pkg::EV_INFECT;
            infected_sites.push_back(nb);
         end
         // only a susceptible active cell can take the vaccine
         if (grid[act] == lev_pkg::CELL_SUS && rq.rvax < vax_thr) begin
            grid[act] = lev_pkg::CELL_VAX;
            sus_total--;
            vax_total++;
            res.kind = lev_pkg::EV_VAX;
         end
      end
      res.cell_st = grid[act];
      res.sus     = 17'(sus_total);
      res.inf     = 17'(inf_total);
      res.vax     = 17'(vax_total);
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      if (sel < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random draw that often lands on or next to the threshold and on the extremes
   function automatic logic [31:0] draw_fraction(logic [31:0] thr);
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return thr;
         3:       return thr - 32'd1;
         4:       return thr + 32'd1;
         default: return $urandom();
      endcase
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int unsigned sel;
      int          site;
      rq.kind = lev_pkg::REQ_UPDATE;
      rq.row  = 8'($urandom());
      rq.col  = 8'($urandom());
      rq.dir  = lev_pkg::dir_type'($urandom_range(0, 3));
      rq.ract = draw_fraction(infect_thr);
      rq.rvax = draw_fraction(vax_thr);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         rq.kind = lev_pkg::REQ_READ;
      end else if (sel < 75) begin
         // aim at a known infected cell so the epidemic actually spreads
         site = infected_sites[$urandom_range(0, infected_sites.size() - 1)];
         rq.row = 8'(site / SIDE);
         rq.col = 8'(site % SIDE);
      end
      return rq;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // offer one request, hold it until taken, then log what the block owes for it
   task automatic issue_request(input request_type rq, input logic is_fixed,
                                input outcome_type want);
      outcome_type predicted;
      int unsigned gap;
      req_valid     <= 1'b1;
      req_type      <= rq.kind;
      req_row       <= rq.row;
      req_col       <= rq.col;
      req_direction <= rq.dir;
      req_rand_act  <= rq.ract;
      req_rand_vax  <= rq.rvax;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_lattice(rq);
      pending_outcomes.push_back(is_fixed ? want : predicted);
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_burst(input int count);
      for (int i = 0; i < count; i++) issue_request(random_request(), 1'b0, '0);
   endtask

   // chain of updates walking straight out of the center, far enough to wrap the torus
   task automatic spread_line(input lev_pkg::dir_type d, input int steps);
      request_type rq;
      int          site;
      site = CENTER;
      for (int i = 0; i < steps; i++) begin
         rq.kind = lev_pkg::REQ_UPDATE;
         rq.row  = 8'(site / SIDE);
         rq.col  = 8'(site % SIDE);
         rq.dir  = d;
         rq.ract = 32'd0;
         rq.rvax = $urandom();
         issue_request(rq, 1'b0, '0);
         site = neighbor_of(site, d);
      end
   endtask

   // stop offering, wait for every owed response, then let the pipeline empty
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // back-to-back writes of both threshold registers
   task automatic write_thresholds(input logic [31:0] infect_val, input logic [31:0] vax_val);
      csr_write <= 1'b1;
      csr_index <= lev_pkg::REG_INFECT_THR;
      csr_wdata <= infect_val;
      @(posedge clock);
      infect_thr = infect_val;
      csr_index <= lev_pkg::REG_VAX_THR;
      csr_wdata <= vax_val;
      @(posedge clock);
      vax_thr = vax_val;
      csr_write <= 1'b0;
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int unsigned gap;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            // long hold-off so the block backs up and stalls its input
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            gap = receiver_quiet ? 0 : pick_gap();
            if (gap == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (gap - 1) @(posedge clock);
            end
         end
      end
   end

   // response checker: every taken response against the oldest owed one
   always @(posedge clock) begin : check_responses
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_cell_state !== want.cell_st)
               report_mismatch($sformatf("cell_state got %0d expected %0d",
                                         rsp_cell_state, want.cell_st));
            if (rsp_event_kind !== want.kind)
               report_mismatch($sformatf("event_kind got %0d expected %0d",
                                         rsp_event_kind, want.kind));
            if (rsp_susceptible_count !== want.sus)
               report_mismatch($sformatf("susceptible_count got %0d expected %0d",
                                         rsp_susceptible_count, want.sus));
            if (rsp_infected_count !== want.inf)
               report_mismatch($sformatf("infected_count got %0d expected %0d",
                                         rsp_infected_count, want.inf));
            if (rsp_vaccinated_count !== want.vax)
               report_mismatch($sformatf("vaccinated_count got %0d expected %0d",
                                         rsp_vaccinated_count, want.vax));
         end
      end
   end

   // watchdog: too long without any handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // bench lattice starts like the block after reset
      foreach (grid[i]) grid[i] = lev_pkg::CELL_SUS;
      grid[CENTER] = lev_pkg::CELL_INF;
      infected_sites.push_back(CENTER);
      sus_total = SIDE * SIDE - 1;
      inf_total = 1;
      vax_total = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: directed table, two wrapping lines, random mix
      foreach (directed_rows[i])
         issue_request(directed_rows[i].rq, directed_rows[i].is_fixed, directed_rows[i].want);
      spread_line(lev_pkg::DIR_ROW_DEC, 140);
      spread_line(lev_pkg::DIR_COL_INC, 140);
      random_burst(220);
      drain_and_settle();

      // infection fires but on all-ones draws, no vaccination; long response hold-off first
      write_thresholds(32'hFFFF_FFFF, 32'd0);
      hold_off_req = 1'b1;
      sender_quiet = 1'b1;
      random_burst(40);
      sender_quiet = 1'b0;
      spread_line(lev_pkg::DIR_ROW_INC, 140);
      spread_line(lev_pkg::DIR_COL_DEC, 140);
      random_burst(180);
      drain_and_settle();

      // infection never fires, vaccination nearly always
      write_thresholds(32'd0, 32'hFFFF_FFFF);
      random_burst(220);
      drain_and_settle();

      // random thresholds, first half with no idling on either side
      write_thresholds($urandom(), $urandom());
      sender_quiet   = 1'b1;
      receiver_quiet = 1'b1;
      random_burst(110);
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      random_burst(110);
      drain_and_settle();

      // even odds on infection, one in four on vaccination
      write_thresholds(32'h8000_0000, 32'h4000_0000);
      random_burst(220);
      drain_and_settle();

      if (pending_outcomes.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_outcomes.size()));
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> lattice_epidemic_vaccination_step.f
rtl/lev_pkg.sv
rtl/lev_ram.sv
rtl/lev_addr.sv
rtl/lattice_epidemic_vaccination_step.sv
tb/lattice_epidemic_vaccination_step_tb.sv
